>>> rtl/pfd_pkg.sv
package pfd_pkg;

   localparam int LENGTH_BITS_DEFAULT = 32;

   localparam logic [2:0] KIND_SCALAR  = 3'd0;
   localparam logic [2:0] KIND_HEADER  = 3'd1;
   localparam logic [2:0] KIND_PAYLOAD = 3'd2;
   localparam logic [2:0] KIND_ERROR   = 3'd3;
   localparam logic [2:0] KIND_END     = 3'd4;

   localparam logic [2:0] CAUSE_NONE     = 3'd0;
   localparam logic [2:0] CAUSE_OVERLONG = 3'd1;
   localparam logic [2:0] CAUSE_TAG      = 3'd2;
   localparam logic [2:0] CAUSE_WIRE     = 3'd3;
   localparam logic [2:0] CAUSE_TRUNC    = 3'd4;

   localparam logic [2:0] WIRE_VARINT  = 3'd0;
   localparam logic [2:0] WIRE_FIXED64 = 3'd1;
   localparam logic [2:0] WIRE_LENGTH  = 3'd2;
   localparam logic [2:0] WIRE_FIXED32 = 3'd5;

   localparam logic [3:0] VARINT_LAST_INDEX = 4'd9;
   localparam logic [6:0] VARINT_DIGIT_BITS = 7'd7;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [28:0] field_number;
      logic [2:0]  wire_type;
      logic [63:0] field_value;
      logic [7:0]  payload_byte;
      logic [2:0]  error_cause;
      logic        message_end;
   } rsp_item_type;

endpackage

>>> rtl/protobuf_field_decoder_top.sv
// Latency: a result is valid in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless stalled; each byte gives at most one result.
// The output register lets a new byte in while a result waits, unless it is stalled.
// Reset is synchronous and active high; it returns the decoder to reading a tag
// and empties the output register.
module protobuf_field_decoder_top #(
   parameter int LENGTH_BITS = pfd_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  pfd_pkg::req_item_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output pfd_pkg::rsp_item_type rsp_data
);

   typedef enum logic [2:0] {
      PH_TAG,
      PH_VALUE,
      PH_LEN,
      PH_FIXED,
      PH_PAYLOAD
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic [63:0]           accumulator_ff, accumulator_in;
   logic [3:0]            byte_index_ff, byte_index_in;
   logic [28:0]           field_ff, field_in;
   logic [2:0]            wire_ff, wire_in;
   logic [LENGTH_BITS-1:0] remaining_ff, remaining_in;
   logic                  error_seen_ff, error_seen_in;
   logic                  rsp_valid_ff;
   pfd_pkg::rsp_item_type rsp_data_ff;

   logic                  accept;
   logic [7:0]            b;
   logic                  last;
   logic [6:0]            vshift;
   logic [63:0]           acc_var;
   logic [63:0]           acc_fix;
   logic                  overlong;
   logic                  more;
   logic [LENGTH_BITS-1:0] rem_dec;
   logic                  len_over;
   logic                  fail;
   logic [2:0]            fail_cause;
   logic                  emit;
   pfd_pkg::rsp_item_type res;

   assign accept    = req_valid && !req_stall;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign b        = req_data.data_byte;
   assign last     = req_data.last_byte;
   assign vshift   = 7'(byte_index_ff) * pfd_pkg::VARINT_DIGIT_BITS;
   assign acc_var  = accumulator_ff | ({57'd0, b[6:0]} << vshift);
   assign acc_fix  = accumulator_ff | ({56'd0, b} << {byte_index_ff[2:0], 3'b000});
   assign overlong = (byte_index_ff > pfd_pkg::VARINT_LAST_INDEX) ||
                     ((byte_index_ff == pfd_pkg::VARINT_LAST_INDEX) && (b > 8'd1));
   assign more     = b[7];
   assign rem_dec  = (remaining_ff != '0) ? remaining_ff - LENGTH_BITS'(1) : remaining_ff;
   assign len_over = |(acc_var >> LENGTH_BITS);

   always_comb begin
      phase_in       = phase_ff;
      accumulator_in = accumulator_ff;
      byte_index_in  = byte_index_ff;
      field_in       = field_ff;
      wire_in        = wire_ff;
      remaining_in   = remaining_ff;
      error_seen_in  = error_seen_ff;
      fail           = 1'b0;
      fail_cause     = pfd_pkg::CAUSE_NONE;
      emit           = 1'b0;
      res            = '0;

      if (error_seen_ff) begin
         if (last) begin
            emit            = 1'b1;
            res.kind        = pfd_pkg::KIND_END;
            res.message_end = 1'b1;
         end
      end else begin
         case (phase_ff)
            PH_TAG: begin
               if (overlong) begin
                  fail       = 1'b1;
                  fail_cause = pfd_pkg::CAUSE_OVERLONG;
               end else if (more) begin
                  accumulator_in = acc_var;
                  byte_index_in  = byte_index_ff + 4'd1;
                  if (last) begin
                     fail       = 1'b1;
                     fail_cause = pfd_pkg::CAUSE_TRUNC;
                  end
               end else begin
                  accumulator_in = '0;
                  byte_index_in  = '0;
                  if ((|acc_var[63:32]) || (acc_var[31:3] == '0)) begin
                     fail       = 1'b1;
                     fail_cause = pfd_pkg::CAUSE_TAG;
                  end else begin
                     field_in = acc_var[31:3];
                     wire_in  = acc_var[2:0];
                     case (acc_var[2:0])
                        pfd_pkg::WIRE_VARINT:  phase_in = PH_VALUE;
                        pfd_pkg::WIRE_LENGTH:  phase_in = PH_LEN;
                        pfd_pkg::WIRE_FIXED32: begin
                           phase_in     = PH_FIXED;
                           remaining_in = LENGTH_BITS'(4);
                        end
                        pfd_pkg::WIRE_FIXED64: begin
                           phase_in     = PH_FIXED;
                           remaining_in = LENGTH_BITS'(8);
                        end
                        default: begin
                           fail       = 1'b1;
                           fail_cause = pfd_pkg::CAUSE_WIRE;
                        end
                     endcase
                     if (last && !fail) begin
                        fail       = 1'b1;
                        fail_cause = pfd_pkg::CAUSE_TRUNC;
                     end
                  end
               end
            end
            PH_VALUE, PH_LEN: begin
               if (overlong) begin
                  fail       = 1'b1;
                  fail_cause = pfd_pkg::CAUSE_OVERLONG;
               end else if (more) begin
                  accumulator_in = acc_var;
                  byte_index_in  = byte_index_ff + 4'd1;
                  if (last) begin
                     fail       = 1'b1;
                     fail_cause = pfd_pkg::CAUSE_TRUNC;
                  end
               end else if (phase_ff == PH_VALUE) begin
                  emit             = 1'b1;
                  res.kind         = pfd_pkg::KIND_SCALAR;
                  res.field_number = field_ff;
                  res.wire_type    = wire_ff;
                  res.field_value  = acc_var;
                  res.message_end  = last;
                  phase_in         = PH_TAG;
                  accumulator_in   = '0;
                  byte_index_in    = '0;
                  remaining_in     = '0;
               end else if (len_over || (last && (acc_var != '0))) begin
                  fail       = 1'b1;
                  fail_cause = pfd_pkg::CAUSE_TRUNC;
               end else begin
                  emit             = 1'b1;
                  res.kind         = pfd_pkg::KIND_HEADER;
                  res.field_number = field_ff;
                  res.wire_type    = wire_ff;
                  res.field_value  = acc_var;
                  res.message_end  = last;
                  accumulator_in   = '0;
                  byte_index_in    = '0;
                  remaining_in     = acc_var[LENGTH_BITS-1:0];
                  phase_in         = (acc_var == '0) ? PH_TAG : PH_PAYLOAD;
               end
            end
            PH_FIXED: begin
               accumulator_in = acc_fix;
               byte_index_in  = byte_index_ff + 4'd1;
               remaining_in   = rem_dec;
               if (rem_dec == '0) begin
                  emit             = 1'b1;
                  res.kind         = pfd_pkg::KIND_SCALAR;
                  res.field_number = field_ff;
                  res.wire_type    = wire_ff;
                  res.field_value  = acc_fix;
                  res.message_end  = last;
                  phase_in         = PH_TAG;
                  accumulator_in   = '0;
                  byte_index_in    = '0;
               end else if (last) begin
                  fail       = 1'b1;
                  fail_cause = pfd_pkg::CAUSE_TRUNC;
               end
            end
            PH_PAYLOAD: begin
               remaining_in = rem_dec;
               if ((rem_dec != '0) && last) begin
                  fail       = 1'b1;
                  fail_cause = pfd_pkg::CAUSE_TRUNC;
               end else begin
                  emit             = 1'b1;
                  res.kind         = pfd_pkg::KIND_PAYLOAD;
                  res.field_number = field_ff;
                  res.wire_type    = wire_ff;
                  res.payload_byte = b;
                  res.message_end  = last;
                  if (rem_dec == '0) begin
                     phase_in       = PH_TAG;
                     accumulator_in = '0;
                     byte_index_in  = '0;
                  end
               end
            end
            default: begin
               phase_in       = PH_TAG;
               accumulator_in = '0;
               byte_index_in  = '0;
               field_in       = '0;
               wire_in        = '0;
               remaining_in   = '0;
            end
         endcase

         if (fail) begin
            emit             = 1'b1;
            res              = '0;
            res.kind         = pfd_pkg::KIND_ERROR;
            res.field_number = field_in;
            res.wire_type    = wire_in;
            res.error_cause  = fail_cause;
            res.message_end  = last;
            error_seen_in    = !last;
         end
      end

      // Every result that closes the message returns the decoder to its reset state.
      if (emit && res.message_end) begin
         phase_in       = PH_TAG;
         accumulator_in = '0;
         byte_index_in  = '0;
         field_in       = '0;
         wire_in        = '0;
         remaining_in   = '0;
         error_seen_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_TAG;
         accumulator_ff <= '0;
         byte_index_ff  <= '0;
         field_ff       <= '0;
         wire_ff        <= '0;
         remaining_ff   <= '0;
         error_seen_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff       <= phase_in;
            accumulator_ff <= accumulator_in;
            byte_index_ff  <= byte_index_in;
            field_ff       <= field_in;
            wire_ff        <= wire_in;
            remaining_ff   <= remaining_in;
            error_seen_ff  <= error_seen_in;
            rsp_valid_ff   <= emit;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= res;
      end
   end

endmodule

>>> tb/sv/field_decode_checker.sv
module field_decode_checker #(
   parameter int LENGTH_BITS = pfd_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  pfd_pkg::req_item_type req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  pfd_pkg::rsp_item_type rsp_data,
   output int                    failures,
   output int                    pending
);

   localparam logic [63:0] LENGTH_LIMIT = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - LENGTH_BITS);

   typedef enum logic [2:0] {
      READ_TAG,
      READ_VALUE,
      READ_LENGTH,
      READ_FIXED,
      READ_PAYLOAD
   } decode_phase_type;

   decode_phase_type dec_phase;
   logic [63:0]      acc;
   logic [3:0]       digit_index;
   logic [28:0]      field_no;
   logic [2:0]       wire_kind;
   logic [63:0]      owed;
   logic             in_error;

   pfd_pkg::rsp_item_type expected_q[$];

   function automatic void restart_all();
      dec_phase   = READ_TAG;
      acc         = '0;
      digit_index = '0;
      field_no    = '0;
      wire_kind   = '0;
      owed        = '0;
      in_error    = 1'b0;
   endfunction

   function automatic void field_done(input logic lst);
      if (lst) begin
         restart_all();
      end else begin
         dec_phase   = READ_TAG;
         acc         = '0;
         digit_index = '0;
         owed        = '0;
      end
   endfunction

   function automatic pfd_pkg::rsp_item_type make_item(
      input logic [2:0] kind, input logic [28:0] fn, input logic [2:0] wt,
      input logic [63:0] val, input logic [7:0] pb, input logic [2:0] cause,
      input logic endf);
      pfd_pkg::rsp_item_type item;
      item.kind         = kind;
      item.field_number = fn;
      item.wire_type    = wt;
      item.field_value  = val;
      item.payload_byte = pb;
      item.error_cause  = cause;
      item.message_end  = endf;
      return item;
   endfunction

   function automatic pfd_pkg::rsp_item_type raise_error(input logic [2:0] cause,
                                                         input logic lst);
      pfd_pkg::rsp_item_type item;
      item = make_item(pfd_pkg::KIND_ERROR, field_no, wire_kind, '0, '0, cause, lst);
      if (lst) begin
         restart_all();
      end else begin
         in_error = 1'b1;
      end
      return item;
   endfunction

   // Returns 1 when the varint is complete, 0 when more digits follow, -1 when overlong.
   function automatic int take_digit(input logic [7:0] b);
      if (digit_index > 9 || (digit_index == 9 && b > 1)) begin
         return -1;
      end
      acc = acc | (64'(b[6:0]) << (7 * digit_index));
      if (!b[7]) begin
         return 1;
      end
      digit_index = digit_index + 1'b1;
      return 0;
   endfunction

   function automatic bit decode_byte(input logic [7:0] b, input logic lst,
                                      output pfd_pkg::rsp_item_type res);
      int          step;
      logic [63:0] tag;
      logic [63:0] len;
      res = '0;
      if (in_error) begin
         if (!lst) begin
            return 0;
         end
         res = make_item(pfd_pkg::KIND_END, '0, '0, '0, '0, pfd_pkg::CAUSE_NONE, 1'b1);
         restart_all();
         return 1;
      end
      case (dec_phase)
         READ_TAG: begin
            step = take_digit(b);
            if (step < 0) begin
               res = raise_error(pfd_pkg::CAUSE_OVERLONG, lst);
               return 1;
            end
            if (step == 0) begin
               if (lst) begin
                  res = raise_error(pfd_pkg::CAUSE_TRUNC, lst);
                  return 1;
               end
               return 0;
            end
            tag         = acc;
            acc         = '0;
            digit_index = '0;
            if (tag > 64'hFFFF_FFFF || tag[63:3] == 0) begin
               res = raise_error(pfd_pkg::CAUSE_TAG, lst);
               return 1;
            end
            field_no  = tag[31:3];
            wire_kind = tag[2:0];
            case (wire_kind)
               pfd_pkg::WIRE_VARINT: begin
                  dec_phase = READ_VALUE;
               end
               pfd_pkg::WIRE_LENGTH: begin
                  dec_phase = READ_LENGTH;
               end
               pfd_pkg::WIRE_FIXED32: begin
                  dec_phase = READ_FIXED;
                  owed      = 64'd4;
               end
               pfd_pkg::WIRE_FIXED64: begin
                  dec_phase = READ_FIXED;
                  owed      = 64'd8;
               end
               default: begin
                  res = raise_error(pfd_pkg::CAUSE_WIRE, lst);
                  return 1;
               end
            endcase
            if (lst) begin
               res = raise_error(pfd_pkg::CAUSE_TRUNC, lst);
               return 1;
            end
            return 0;
         end
         READ_VALUE: begin
            step = take_digit(b);
            if (step < 0) begin
               res = raise_error(pfd_pkg::CAUSE_OVERLONG, lst);
               return 1;
            end
            if (step == 0) begin
               if (lst) begin
                  res = raise_error(pfd_pkg::CAUSE_TRUNC, lst);
                  return 1;
               end
               return 0;
            end
            res = make_item(pfd_pkg::KIND_SCALAR, field_no, wire_kind, acc, '0,
                            pfd_pkg::CAUSE_NONE, lst);
            field_done(lst);
            return 1;
         end
         READ_LENGTH: begin
            step = take_digit(b);
            if (step < 0) begin
               res = raise_error(pfd_pkg::CAUSE_OVERLONG, lst);
               return 1;
            end
            if (step == 0) begin
               if (lst) begin
                  res = raise_error(pfd_pkg::CAUSE_TRUNC, lst);
                  return 1;
               end
               return 0;
            end
            len = acc;
            if (len > LENGTH_LIMIT || (lst && len != 0)) begin
               res = raise_error(pfd_pkg::CAUSE_TRUNC, lst);
               return 1;
            end
            res = make_item(pfd_pkg::KIND_HEADER, field_no, wire_kind, len, '0,
                            pfd_pkg::CAUSE_NONE, lst);
            if (len == 0) begin
               field_done(lst);
            end else begin
               dec_phase   = READ_PAYLOAD;
               acc         = '0;
               digit_index = '0;
               owed        = len;
            end
            return 1;
         end
         READ_FIXED: begin
            acc         = acc | (64'(b) << (8 * digit_index[2:0]));
            digit_index = digit_index + 1'b1;
            if (owed > 0) begin
               owed = owed - 1;
            end
            if (owed == 0) begin
               res = make_item(pfd_pkg::KIND_SCALAR, field_no, wire_kind, acc, '0,
                               pfd_pkg::CAUSE_NONE, lst);
               field_done(lst);
               return 1;
            end
            if (lst) begin
               res = raise_error(pfd_pkg::CAUSE_TRUNC, lst);
               return 1;
            end
            return 0;
         end
         READ_PAYLOAD: begin
            if (owed > 0) begin
               owed = owed - 1;
            end
            if (owed != 0 && lst) begin
               res = raise_error(pfd_pkg::CAUSE_TRUNC, lst);
               return 1;
            end
            res = make_item(pfd_pkg::KIND_PAYLOAD, field_no, wire_kind, '0, b,
                            pfd_pkg::CAUSE_NONE, owed == 0 && lst);
            if (owed == 0) begin
               field_done(lst);
            end
            return 1;
         end
         default: begin
            restart_all();
            return 0;
         end
      endcase
   endfunction

   always @(posedge clock) begin : watch
      pfd_pkg::rsp_item_type want;
      pfd_pkg::rsp_item_type fresh;
      if (reset) begin
         restart_all();
         expected_q.delete();
         failures = 0;
         pending <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               if (failures < 10) begin
                  $display("result with no item pending: kind %0d field %0d value %h",
                           rsp_data.kind, rsp_data.field_number, rsp_data.field_value);
               end
               failures++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.kind !== want.kind || rsp_data.field_number !== want.field_number ||
                   rsp_data.wire_type !== want.wire_type ||
                   rsp_data.field_value !== want.field_value ||
                   rsp_data.payload_byte !== want.payload_byte ||
                   rsp_data.error_cause !== want.error_cause ||
                   rsp_data.message_end !== want.message_end) begin
                  if (failures < 10) begin
                     $display({"mismatch: expected kind %0d field %0d wire %0d value %h",
                               " byte %h cause %0d end %0b"},
                              want.kind, want.field_number, want.wire_type, want.field_value,
                              want.payload_byte, want.error_cause, want.message_end);
                     $display({"          actual   kind %0d field %0d wire %0d value %h",
                               " byte %h cause %0d end %0b"},
                              rsp_data.kind, rsp_data.field_number, rsp_data.wire_type,
                              rsp_data.field_value, rsp_data.payload_byte, rsp_data.error_cause,
                              rsp_data.message_end);
                  end
                  failures++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (decode_byte(req_data.data_byte, req_data.last_byte, fresh)) begin
               expected_q.push_back(fresh);
            end
         end
         pending <= expected_q.size();
      end
   end

endmodule

>>> tb/sv/protobuf_field_decoder_top_test.sv
module protobuf_field_decoder_top_test;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   pfd_pkg::req_item_type req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   pfd_pkg::rsp_item_type rsp_data;

   int           failures;
   int           pending;
   int           cycle_count    = 0;
   int           send_idle_pct  = 0;
   int           recv_stall_pct = 0;
   int           bytes_made     = 0;
   logic         long_hold      = 1'b0;

   pfd_pkg::req_item_type byte_q[$];
   logic [7:0]            msg_q[$];

   protobuf_field_decoder_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   field_decode_checker scoreboard (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .failures  (failures),
      .pending   (pending)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("protobuf_field_decoder_top_test: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else if (!req_valid || !req_stall) begin
         if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data  <= byte_q.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= long_hold || ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic push_varint(input logic [63:0] v);
      logic [7:0] b;
      do begin
         b = {1'b0, v[6:0]};
         v = v >> 7;
         if (v != 0) begin
            b[7] = 1'b1;
         end
         msg_q.push_back(b);
      end while (v != 0);
   endtask

   function automatic logic [63:0] random_value();
      int          nbits;
      logic [63:0] v;
      nbits = $urandom_range(0, 64);
      v     = {$urandom, $urandom};
      if (nbits < 64) begin
         v = v & ((64'd1 << nbits) - 1);
      end
      return v;
   endfunction

   function automatic logic [28:0] pick_field_number();
      int roll;
      roll = $urandom_range(99);
      if (roll < 70) begin
         return 29'($urandom_range(1, 15));
      end
      if (roll < 90) begin
         return 29'($urandom_range(16, 2047));
      end
      return 29'($urandom_range(1, 29'h1FFF_FFFF));
   endfunction

   task automatic put_tag(input logic [28:0] fn, input logic [2:0] wt);
      push_varint((64'(fn) << 3) | 64'(wt));
   endtask

   task automatic put_field();
      logic [28:0] fn;
      logic [2:0]  wt;
      int          len;
      fn = pick_field_number();
      case ($urandom_range(0, 3))
         0:       wt = pfd_pkg::WIRE_VARINT;
         1:       wt = pfd_pkg::WIRE_FIXED64;
         2:       wt = pfd_pkg::WIRE_LENGTH;
         default: wt = pfd_pkg::WIRE_FIXED32;
      endcase
      put_tag(fn, wt);
      case (wt)
         pfd_pkg::WIRE_VARINT: begin
            push_varint(random_value());
         end
         pfd_pkg::WIRE_FIXED64: begin
            repeat (8) msg_q.push_back(8'($urandom));
         end
         pfd_pkg::WIRE_FIXED32: begin
            repeat (4) msg_q.push_back(8'($urandom));
         end
         default: begin
            len = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 5) : $urandom_range(6, 24);
            push_varint(64'(len));
            repeat (len) msg_q.push_back(8'($urandom));
         end
      endcase
   endtask

   task automatic put_defect();
      logic [2:0] wt;
      case ($urandom_range(0, 5))
         0: begin
            do begin
               wt = 3'($urandom_range(0, 7));
            end while (wt == pfd_pkg::WIRE_VARINT || wt == pfd_pkg::WIRE_FIXED64 ||
                       wt == pfd_pkg::WIRE_LENGTH || wt == pfd_pkg::WIRE_FIXED32);
            put_tag(pick_field_number(), wt);
         end
         1: begin
            push_varint(64'($urandom_range(0, 7)));
         end
         2: begin
            push_varint({$urandom, $urandom} | 64'h1_0000_0000);
         end
         3: begin
            if ($urandom_range(0, 1) == 1) begin
               put_tag(pick_field_number(), pfd_pkg::WIRE_VARINT);
            end
            repeat (9) msg_q.push_back(8'h80 | 8'($urandom_range(0, 127)));
            if ($urandom_range(0, 1) == 1) begin
               msg_q.push_back(8'($urandom_range(2, 127)));
            end else begin
               msg_q.push_back(8'h80 | 8'($urandom_range(0, 127)));
            end
         end
         4: begin
            put_tag(pick_field_number(), pfd_pkg::WIRE_LENGTH);
            push_varint({$urandom, $urandom} | 64'h1_0000_0000);
         end
         default: begin
            repeat ($urandom_range(1, 8)) msg_q.push_back(8'($urandom));
         end
      endcase
   endtask

   task automatic queue_message();
      pfd_pkg::req_item_type item;
      for (int i = 0; i < msg_q.size(); i++) begin
         item.data_byte = msg_q[i];
         item.last_byte = (i == msg_q.size() - 1);
         byte_q.push_back(item);
      end
      bytes_made += msg_q.size();
   endtask

   task automatic make_message();
      int roll;
      int cut;
      msg_q.delete();
      roll = $urandom_range(99);
      repeat ($urandom_range(1, 4)) put_field();
      if (roll < 12) begin
         put_defect();
         repeat ($urandom_range(0, 3)) msg_q.push_back(8'($urandom));
      end else if (roll < 20) begin
         cut = $urandom_range(0, msg_q.size() - 1);
         while (msg_q.size() > cut + 1) begin
            void'(msg_q.pop_back());
         end
      end
      queue_message();
   endtask

   task automatic wait_drained();
      while (byte_q.size() != 0 || req_valid || pending != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct, input int nbytes);
      int target;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      target         = bytes_made + nbytes;
      while (bytes_made < target) begin
         make_message();
      end
      wait_drained();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Zero-length field, a two-byte payload, then a truncated fixed32 field.
      msg_q = '{8'h0A, 8'h00, 8'h12, 8'h02, 8'hAA, 8'h55, 8'h0D, 8'hFF, 8'h00, 8'h80};
      queue_message();
      // Bad wire type, then the end of the message after the error.
      msg_q = '{8'h0B, 8'h00};
      queue_message();
      // Field number zero on the final byte.
      msg_q = '{8'h00};
      queue_message();
      // Tag above 32 bits.
      msg_q = '{8'h80, 8'h80, 8'h80, 8'h80, 8'h10};
      queue_message();
      // Message ends inside a varint value.
      msg_q = '{8'h08, 8'h80};
      queue_message();
      // Length beyond the counter width.
      msg_q = '{8'h0A, 8'h80, 8'h80, 8'h80, 8'h80, 8'h10};
      queue_message();
      // Overlong tag varint.
      msg_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h02};
      queue_message();
      wait_drained();

      run_phase(0, 0, 110);
      run_phase(51, 0, 110);
      run_phase(0, 51, 110);
      run_phase(23, 23, 110);

      // The receiver holds off for a long stretch while bytes keep coming.
      fork
         begin
            @(posedge clock);
            long_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold <= 1'b0;
         end
      join_none
      run_phase(0, 0, 60);

      repeat (8) @(negedge clock);
      if (failures == 0 && pending == 0) begin
         $display("protobuf_field_decoder_top_test: PASS");
      end else begin
         $display("protobuf_field_decoder_top_test: FAIL");
      end
      $finish;
   end

endmodule
